// File: rtl/vgr_pkg.sv
package vgr_pkg;

   localparam int DATA_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF  = 16;

   localparam int CSR_DW = 31;
   localparam int CSR_AW = 3;

   localparam logic [CSR_AW-1:0] CSR_MODE    = 3'd0;
   localparam logic [CSR_AW-1:0] CSR_MAX     = 3'd1;
   localparam logic [CSR_AW-1:0] CSR_REFMAX  = 3'd2;
   localparam logic [CSR_AW-1:0] CSR_FREQ    = 3'd3;
   localparam logic [CSR_AW-1:0] CSR_DAMP    = 3'd4;
   localparam logic [CSR_AW-1:0] CSR_GAIN    = 3'd5;

   localparam logic OP_STEP  = 1'b0;
   localparam logic OP_START = 1'b1;

   localparam logic [3:0]  MODE_RST   = 4'd2;
   localparam logic [30:0] MAX_RST    = 31'd327680;
   localparam logic [30:0] REFMAX_RST = 31'd196608;
   localparam logic [19:0] FREQ_RST   = 20'd6554;
   localparam logic [17:0] DAMP_RST   = 18'd58982;
   localparam logic [19:0] GAIN_RST   = 20'd6554;

   localparam int MODE_CTRL  = 0;
   localparam int MODE_REF   = 1;
   localparam int MODE_ALT   = 2;
   localparam int MODE_NOHV  = 3;

   typedef struct packed {
      logic start;
      logic sqrt_sel;
   } rd_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } rd_sts_type;

endpackage

// File: rtl/velocity_guidance_refmodel_core.sv
// Three-axis velocity guidance with a second-order target prefilter.
// Input channel req_*: one item per transfer. op=1 loads the reference
// position/velocity from the measured values and latches wn/xi; no result.
// op=0 is a control step; it yields one rsp_* transfer when the controller
// bit of the mode register is set, otherwise nothing.
// Registers are written through csr_wr_en/csr_index/csr_wdata; the user
// must write them only while idle, as the block has no check for it.
// Start items and disabled steps leave the block ready. An enabled step
// runs on one shared multiplier and one bit-serial root/divide unit that
// yields DATA_WIDTH bits per square root or quotient. A norm check takes
// a square root of the sum of squares and, when it limits, one divide per
// axis. req_stall stays high while a step is in work, and longer while a
// stalled result holds the output register. One item is in work at a time.
// The result sits in an output register; the next item is accepted while
// it waits. If rsp_stall holds it, the following result waits in the
// sequencer until the register frees.
// Reset (synchronous) clears the reference state, the registers to their
// defaults and the output valid.
module velocity_guidance_refmodel_core #(
   parameter int DATA_WIDTH = vgr_pkg::DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = vgr_pkg::FRAC_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_op,
   input  logic signed [31:0]          req_pos_x,
   input  logic signed [31:0]          req_pos_y,
   input  logic signed [31:0]          req_pos_z,
   input  logic signed [31:0]          req_start_vel_x,
   input  logic signed [31:0]          req_start_vel_y,
   input  logic signed [31:0]          req_start_vel_z,
   input  logic signed [31:0]          req_target_x,
   input  logic signed [31:0]          req_target_y,
   input  logic signed [31:0]          req_target_z,
   input  logic [16:0]                 req_dt,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [31:0]          rsp_cmd_u,
   output logic signed [31:0]          rsp_cmd_v,
   output logic signed [31:0]          rsp_cmd_w,
   output logic                        rsp_heave_valid,
   input  logic                        csr_wr_en,
   input  logic [vgr_pkg::CSR_AW-1:0]  csr_index,
   input  logic [vgr_pkg::CSR_DW-1:0]  csr_wdata
);

   localparam int D  = DATA_WIDTH;
   localparam int MW = (D > 31) ? D : 31;
   localparam int XW = ((D > 32) ? D : 32) + 2;

   localparam logic signed [XW-1:0] DMAX   = (XW'(1) <<< (D-1)) - XW'(1);
   localparam logic signed [XW-1:0] DMIN   = -DMAX - XW'(1);
   localparam logic signed [XW-1:0] O32MAX = (XW'(1) <<< 31) - XW'(1);
   localparam logic signed [XW-1:0] O32MIN = -O32MAX - XW'(1);

   localparam logic [4:0] S_IDLE = 5'd0,  S_WN2 = 5'd1,  S_C   = 5'd2,  S_C2  = 5'd3,
                          S_E    = 5'd4,  S_M1  = 5'd5,  S_M2  = 5'd6,  S_M3  = 5'd7,
                          S_M4   = 5'd8,  S_M5  = 5'd9,  S_RLIM = 5'd10, S_PD = 5'd11,
                          S_PM   = 5'd12, S_PC  = 5'd13, S_OD  = 5'd14, S_OM  = 5'd15,
                          S_OC   = 5'd16, S_FLIM = 5'd17, S_N0 = 5'd18, S_N1  = 5'd19,
                          S_N2   = 5'd20, S_N3  = 5'd21, S_D0  = 5'd22, S_D1  = 5'd23,
                          S_D2   = 5'd24, S_NRET = 5'd25, S_OUT = 5'd26;

   function automatic logic signed [D-1:0] satx(input logic signed [XW-1:0] x);
      logic signed [D-1:0] r;
      r = x[D-1:0];
      if (x > DMAX) r = DMAX[D-1:0];
      else if (x < DMIN) r = DMIN[D-1:0];
      return r;
   endfunction

   function automatic logic signed [D-1:0] add_sat(input logic signed [D-1:0] a,
                                                   input logic signed [D-1:0] b);
      return satx(XW'(a) + XW'(b));
   endfunction

   function automatic logic signed [D-1:0] sub_sat(input logic signed [D-1:0] a,
                                                   input logic signed [D-1:0] b);
      return satx(XW'(a) - XW'(b));
   endfunction

   function automatic logic signed [31:0] out_val(input logic signed [D-1:0] v);
      logic signed [XW-1:0] x;
      x = XW'(v);
      if (x > O32MAX) x = O32MAX;
      else if (x < O32MIN) x = O32MIN;
      return x[31:0];
   endfunction

   function automatic logic [D-1:0] mag(input logic signed [D-1:0] v);
      return v[D-1] ? (~v + 1'b1) : v;
   endfunction

   // registers
   logic [3:0]  mode_ff;
   logic [30:0] max_ff, refmax_ff;
   logic [19:0] freq_ff, gain_ff, lf_ff;
   logic [17:0] damp_ff, ld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= vgr_pkg::MODE_RST;
         max_ff    <= vgr_pkg::MAX_RST;
         refmax_ff <= vgr_pkg::REFMAX_RST;
         freq_ff   <= vgr_pkg::FREQ_RST;
         damp_ff   <= vgr_pkg::DAMP_RST;
         gain_ff   <= vgr_pkg::GAIN_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            vgr_pkg::CSR_MODE:   mode_ff   <= csr_wdata[3:0];
            vgr_pkg::CSR_MAX:    max_ff    <= csr_wdata;
            vgr_pkg::CSR_REFMAX: refmax_ff <= csr_wdata;
            vgr_pkg::CSR_FREQ:   freq_ff   <= csr_wdata[19:0];
            vgr_pkg::CSR_DAMP:   damp_ff   <= csr_wdata[17:0];
            vgr_pkg::CSR_GAIN:   gain_ff   <= csr_wdata[19:0];
            default: ;
         endcase
      end
   end

   // datapath state
   logic [4:0]          state_ff;
   logic [1:0]          idx_ff;
   logic signed [D-1:0] rp_ff [3];
   logic signed [D-1:0] rv_ff [3];
   logic signed [D-1:0] pos_ff [3];
   logic signed [D-1:0] tgt_ff [3];
   logic signed [D-1:0] w_ff [3];
   logic [16:0]         dt_ff;
   logic signed [D-1:0] wn2_ff, c_ff, e_ff, t1_ff, a_ff;
   logic [2*D-1:0]      s_ff;
   logic [D-1:0]        n_ff;
   logic                ret_ff, lmt_ff;
   logic                rsp_valid_ff, rsp_hv_ff;
   logic signed [31:0]  rsp_u_ff, rsp_v_ff, rsp_w_ff;

   logic [MW-1:0]       ma, mb;
   logic                mneg;
   logic [2*MW-1:0]     prod;
   logic signed [D-1:0] mq;
   logic [D-1:0]        rres;
   vgr_pkg::rd_ctl_type rctl;
   vgr_pkg::rd_sts_type rsts;
   logic [MW-1:0]       lim;
   logic                accept;
   logic                alt;

   assign alt    = mode_ff[vgr_pkg::MODE_ALT];
   assign lim    = ret_ff ? MW'(max_ff) : MW'(refmax_ff);
   assign accept = req_valid && !req_stall;

   vgr_mul #(.DATA_WIDTH(D), .FRAC_BITS(FRAC_BITS), .MW(MW)) u_mul (
      .clock   (clock),
      .ma      (ma),
      .mb      (mb),
      .neg     (mneg),
      .prod_ff (prod),
      .q_ff    (mq)
   );

   vgr_rdiv #(.DATA_WIDTH(D), .MW(MW)) u_rdiv (
      .clock (clock),
      .reset (reset),
      .ctl   (rctl),
      .rad   (s_ff),
      .num   (prod),
      .den   (n_ff),
      .res   (rres),
      .sts   (rsts)
   );

   // multiplier operand select
   always_comb begin
      ma   = '0;
      mb   = '0;
      mneg = 1'b0;
      unique case (state_ff)
         S_WN2: begin
            ma = MW'(lf_ff);
            mb = MW'(lf_ff);
         end
         S_C: begin
            ma = MW'(lf_ff);
            mb = MW'(ld_ff);
         end
         S_M1: begin
            ma   = MW'(mag(wn2_ff));
            mb   = MW'(mag(e_ff));
            mneg = wn2_ff[D-1] ^ e_ff[D-1];
         end
         S_M2: begin
            ma   = MW'(mag(c_ff));
            mb   = MW'(mag(rv_ff[idx_ff]));
            mneg = c_ff[D-1] ^ rv_ff[idx_ff][D-1];
         end
         S_M3: begin
            ma   = MW'(dt_ff);
            mb   = MW'(mag(rv_ff[idx_ff]));
            mneg = rv_ff[idx_ff][D-1];
         end
         S_M4: begin
            ma   = MW'(dt_ff);
            mb   = MW'(mag(a_ff));
            mneg = a_ff[D-1];
         end
         S_PM, S_OM: begin
            ma   = MW'(gain_ff);
            mb   = MW'(mag(e_ff));
            mneg = e_ff[D-1];
         end
         S_N0: begin
            ma = MW'(mag(w_ff[idx_ff]));
            mb = MW'(mag(w_ff[idx_ff]));
         end
         S_D0: begin
            ma = lim;
            mb = MW'(mag(w_ff[idx_ff]));
         end
         default: ;
      endcase
   end

   always_comb begin
      rctl.start    = (state_ff == S_N2) || (state_ff == S_D1);
      rctl.sqrt_sel = (state_ff == S_N2);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         lf_ff        <= vgr_pkg::FREQ_RST;
         ld_ff        <= vgr_pkg::DAMP_RST;
         for (int k = 0; k < 3; k++) begin
            rp_ff[k] <= '0;
            rv_ff[k] <= '0;
         end
      end else begin
         // S_OUT loads the register itself
         if (rsp_valid_ff && !rsp_stall && (state_ff != S_OUT)) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  pos_ff[0] <= satx(XW'(req_pos_x));
                  pos_ff[1] <= satx(XW'(req_pos_y));
                  pos_ff[2] <= satx(XW'(req_pos_z));
                  tgt_ff[0] <= satx(XW'(req_target_x));
                  tgt_ff[1] <= satx(XW'(req_target_y));
                  tgt_ff[2] <= satx(-XW'(req_target_z));
                  dt_ff     <= req_dt;
                  idx_ff    <= '0;
                  if (req_op == vgr_pkg::OP_START) begin
                     rp_ff[0] <= satx(XW'(req_pos_x));
                     rp_ff[1] <= satx(XW'(req_pos_y));
                     rp_ff[2] <= satx(XW'(req_pos_z));
                     rv_ff[0] <= satx(XW'(req_start_vel_x));
                     rv_ff[1] <= satx(XW'(req_start_vel_y));
                     rv_ff[2] <= satx(XW'(req_start_vel_z));
                     lf_ff    <= freq_ff;
                     ld_ff    <= damp_ff;
                  end else if (mode_ff[vgr_pkg::MODE_CTRL]) begin
                     state_ff <= mode_ff[vgr_pkg::MODE_REF] ? S_WN2 : S_OD;
                  end
               end
            end
            S_WN2: state_ff <= S_C;
            S_C: begin
               wn2_ff   <= mq;
               state_ff <= S_C2;
            end
            S_C2: begin
               // doubling of a non-negative product saturates
               c_ff     <= mq[D-2] ? DMAX[D-1:0] : {mq[D-2:0], 1'b0};
               state_ff <= S_E;
            end
            S_E: begin
               e_ff     <= sub_sat(tgt_ff[idx_ff], rp_ff[idx_ff]);
               state_ff <= S_M1;
            end
            S_M1: state_ff <= S_M2;
            S_M2: begin
               t1_ff    <= mq;
               state_ff <= S_M3;
            end
            S_M3: begin
               a_ff     <= sub_sat(t1_ff, mq);
               state_ff <= S_M4;
            end
            S_M4: begin
               rp_ff[idx_ff] <= add_sat(rp_ff[idx_ff], mq);
               state_ff      <= S_M5;
            end
            S_M5: begin
               rv_ff[idx_ff] <= add_sat(rv_ff[idx_ff], mq);
               if (idx_ff == 2'd2) begin
                  state_ff <= S_RLIM;
               end else begin
                  idx_ff   <= idx_ff + 1'b1;
                  state_ff <= S_E;
               end
            end
            S_RLIM: begin
               w_ff[0]  <= rv_ff[0];
               w_ff[1]  <= rv_ff[1];
               w_ff[2]  <= alt ? rv_ff[2] : '0;
               ret_ff   <= 1'b0;
               s_ff     <= '0;
               idx_ff   <= '0;
               state_ff <= S_N0;
            end
            S_PD: begin
               e_ff     <= sub_sat(rp_ff[idx_ff], pos_ff[idx_ff]);
               state_ff <= S_PM;
            end
            S_PM: state_ff <= S_PC;
            S_PC: begin
               w_ff[idx_ff] <= add_sat(rv_ff[idx_ff], mq);
               if (idx_ff == 2'd2) begin
                  state_ff <= S_FLIM;
               end else begin
                  idx_ff   <= idx_ff + 1'b1;
                  state_ff <= S_PD;
               end
            end
            S_OD: begin
               e_ff     <= sub_sat(tgt_ff[idx_ff], pos_ff[idx_ff]);
               state_ff <= S_OM;
            end
            S_OM: state_ff <= S_OC;
            S_OC: begin
               w_ff[idx_ff] <= mq;
               if (idx_ff == 2'd2) begin
                  state_ff <= S_FLIM;
               end else begin
                  idx_ff   <= idx_ff + 1'b1;
                  state_ff <= S_OD;
               end
            end
            S_FLIM: begin
               if (!alt) w_ff[2] <= '0;
               ret_ff   <= 1'b1;
               s_ff     <= '0;
               idx_ff   <= '0;
               state_ff <= S_N0;
            end
            S_N0: state_ff <= S_N1;
            S_N1: begin
               s_ff <= s_ff + prod[2*D-1:0];
               if (idx_ff == 2'd2) begin
                  state_ff <= S_N2;
               end else begin
                  idx_ff   <= idx_ff + 1'b1;
                  state_ff <= S_N0;
               end
            end
            S_N2: state_ff <= S_N3;
            S_N3: begin
               if (rsts.done) begin
                  n_ff   <= rres;
                  idx_ff <= '0;
                  if (MW'(rres) > lim) begin
                     state_ff <= S_D0;
                  end else begin
                     lmt_ff   <= 1'b0;
                     state_ff <= S_NRET;
                  end
               end
            end
            S_D0: state_ff <= S_D1;
            S_D1: state_ff <= S_D2;
            S_D2: begin
               if (rsts.done) begin
                  w_ff[idx_ff] <= w_ff[idx_ff][D-1] ? (~rres + 1'b1) : rres;
                  if (idx_ff == 2'd2) begin
                     lmt_ff   <= 1'b1;
                     state_ff <= S_NRET;
                  end else begin
                     idx_ff   <= idx_ff + 1'b1;
                     state_ff <= S_D0;
                  end
               end
            end
            S_NRET: begin
               idx_ff <= '0;
               if (ret_ff) begin
                  state_ff <= S_OUT;
               end else begin
                  if (lmt_ff) begin
                     for (int k = 0; k < 3; k++) rv_ff[k] <= w_ff[k];
                  end
                  state_ff <= S_PD;
               end
            end
            S_OUT: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_u_ff     <= out_val(w_ff[0]);
                  rsp_v_ff     <= out_val(w_ff[1]);
                  rsp_w_ff     <= out_val(w_ff[2]);
                  rsp_hv_ff    <= !mode_ff[vgr_pkg::MODE_NOHV];
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_stall       = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_cmd_u       = rsp_u_ff;
   assign rsp_cmd_v       = rsp_v_ff;
   assign rsp_cmd_w       = rsp_w_ff;
   assign rsp_heave_valid = rsp_hv_ff;

endmodule

// File: rtl/vgr_mul.sv
module vgr_mul #(
   parameter int DATA_WIDTH = vgr_pkg::DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = vgr_pkg::FRAC_BITS_DEF,
   parameter int MW         = 32
) (
   input  logic                         clock,
   input  logic [MW-1:0]                ma,
   input  logic [MW-1:0]                mb,
   input  logic                         neg,
   output logic [2*MW-1:0]              prod_ff,
   output logic signed [DATA_WIDTH-1:0] q_ff
);

   localparam int D = DATA_WIDTH;
   localparam logic [2*MW-1:0] PMAX = ((2*MW)'(1) << (D-1)) - (2*MW)'(1);
   localparam logic [2*MW-1:0] NMAG = (2*MW)'(1) << (D-1);

   logic [2*MW-1:0]       p;
   logic [2*MW-1:0]       qi;
   logic [D-1:0]          ql;
   logic signed [D-1:0]   q_in;

   always_comb begin
      p  = ma * mb;
      // floor of a negative product: round the magnitude up
      qi = (p >> FRAC_BITS) + (2*MW)'(neg && (p[FRAC_BITS-1:0] != '0));
      ql = qi[D-1:0];
      if (!neg) begin
         q_in = (qi > PMAX) ? PMAX[D-1:0] : ql;
      end else begin
         q_in = (qi > NMAG) ? NMAG[D-1:0] : (~ql + 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= p;
      q_ff    <= q_in;
   end

endmodule

// File: rtl/vgr_rdiv.sv
module vgr_rdiv #(
   parameter int DATA_WIDTH = vgr_pkg::DATA_WIDTH_DEF,
   parameter int MW         = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  vgr_pkg::rd_ctl_type         ctl,
   input  logic [2*DATA_WIDTH-1:0]     rad,
   input  logic [2*MW-1:0]             num,
   input  logic [DATA_WIDTH-1:0]       den,
   output logic [DATA_WIDTH-1:0]       res,
   output vgr_pkg::rd_sts_type         sts
);

   localparam int D  = DATA_WIDTH;
   localparam int CW = $clog2(D+1);

   logic          busy_ff, done_ff, sq_ff;
   logic [CW-1:0] cnt_ff;
   logic [2*D-1:0] sh_ff;
   logic [D:0]    rem_ff;
   logic [D-1:0]  root_ff;

   logic [D+2:0]  cand, trial, diff;
   logic          ge;

   // one shared compare/subtract: root digit or quotient bit per cycle
   always_comb begin
      cand  = sq_ff ? {rem_ff, sh_ff[2*D-1:2*D-2]} : {1'b0, rem_ff, sh_ff[2*D-1]};
      trial = sq_ff ? {1'b0, root_ff, 2'b01} : {3'b000, den};
      ge    = cand >= trial;
      diff  = cand - trial;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (ctl.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CW'(D);
            sq_ff   <= ctl.sqrt_sel;
            root_ff <= '0;
            if (ctl.sqrt_sel) begin
               sh_ff  <= rad;
               rem_ff <= '0;
            end else begin
               // quotient fits D bits, so upper part of num is below den
               sh_ff  <= {num[D-1:0], {D{1'b0}}};
               rem_ff <= {1'b0, num[2*D-1:D]};
            end
         end else if (busy_ff) begin
            rem_ff  <= ge ? diff[D:0] : cand[D:0];
            root_ff <= {root_ff[D-2:0], ge};
            sh_ff   <= sq_ff ? (sh_ff << 2) : (sh_ff << 1);
            cnt_ff  <= cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign res      = root_ff;
   assign sts.busy = busy_ff;
   assign sts.done = done_ff;

endmodule

// File: rtl/vgr_checker.sv
module vgr_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               req_op,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [31:0] rsp_cmd_u,
   input logic signed [31:0] rsp_cmd_v,
   input logic signed [31:0] rsp_cmd_w,
   input logic               rsp_heave_valid
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_cmd_u) && $stable(rsp_cmd_v)
                                 && $stable(rsp_cmd_w) && $stable(rsp_heave_valid))
      else $error("stalled result changed");

   // a new result only appears after work in progress
   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result without work in progress");

   // start items finish at once and leave the block ready
   a_start_quick: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_op == vgr_pkg::OP_START) |=> !req_stall)
      else $error("start item held the block");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("reset left output valid or block busy");

endmodule

bind velocity_guidance_refmodel_core vgr_checker u_vgr_checker (.*);

// File: tb/velocity_guidance_refmodel_core_chk.sv
module velocity_guidance_refmodel_core_chk (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_stall,
   input  logic                       req_op,
   input  logic signed [31:0]         req_pos_x,
   input  logic signed [31:0]         req_pos_y,
   input  logic signed [31:0]         req_pos_z,
   input  logic signed [31:0]         req_start_vel_x,
   input  logic signed [31:0]         req_start_vel_y,
   input  logic signed [31:0]         req_start_vel_z,
   input  logic signed [31:0]         req_target_x,
   input  logic signed [31:0]         req_target_y,
   input  logic signed [31:0]         req_target_z,
   input  logic [16:0]                req_dt,
   input  logic                       rsp_valid,
   input  logic                       rsp_stall,
   input  logic signed [31:0]         rsp_cmd_u,
   input  logic signed [31:0]         rsp_cmd_v,
   input  logic signed [31:0]         rsp_cmd_w,
   input  logic                       rsp_heave_valid,
   input  logic                       csr_wr_en,
   input  logic [vgr_pkg::CSR_AW-1:0] csr_index,
   input  logic [vgr_pkg::CSR_DW-1:0] csr_wdata,
   output int                         fail_count,
   output int                         cmds_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef logic signed [63:0] q_type;

   typedef struct {
      logic signed [31:0] u;
      logic signed [31:0] v;
      logic signed [31:0] w;
      logic               heave;
   } cmd_type;

   cmd_type expected_cmds[$];

   q_type       ref_pos[3];
   q_type       ref_vel[3];
   logic [3:0]  mode;
   logic [30:0] max_spd, ref_max_spd;
   logic [19:0] wn_reg, gain_reg, wn_held;
   logic [17:0] xi_reg, xi_held;

   assign cmds_pending = expected_cmds.size();

   function automatic q_type clamp32(input q_type x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
   endfunction

   // floor(a*b / 2^16) saturated to 32 bits; operands are at most 32 bits so the product fits
   function automatic q_type qmul(input q_type a, input q_type b);
      q_type p;
      p = a * b;
      return clamp32(p >>> 16);
   endfunction

   function automatic logic [63:0] magn(input q_type x);
      return x < 0 ? 64'(-x) : 64'(x);
   endfunction

   function automatic bit clip_norm(ref q_type vec[3], input logic [63:0] lim);
      logic [127:0] sum, tt, quo;
      logic [63:0]  root, trial;
      sum = 0;
      for (int i = 0; i < 3; i++)
         sum += {64'b0, magn(vec[i])} * {64'b0, magn(vec[i])};
      root = 0;
      for (int b = 63; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         tt = {64'b0, trial};
         if (tt * tt <= sum) root = trial;
      end
      if (root <= lim) return 0;
      for (int i = 0; i < 3; i++) begin
         quo = ({64'b0, lim} * {64'b0, magn(vec[i])}) / {64'b0, root};
         vec[i] = vec[i] < 0 ? -q_type'(quo[63:0]) : q_type'(quo[63:0]);
      end
      return 1;
   endfunction

   function automatic void guidance_step(output bit has_cmd, output cmd_type c);
      q_type pos[3], tgt[3], cmd[3], vec[3];
      q_type wn2, damp2, err, acc, dt;
      bit    alt;
      has_cmd = 0;
      c = '{default: '0};
      pos[0] = req_pos_x;
      pos[1] = req_pos_y;
      pos[2] = req_pos_z;
      alt = mode[vgr_pkg::MODE_ALT];
      if (req_op == vgr_pkg::OP_START) begin
         ref_pos = pos;
         ref_vel[0] = req_start_vel_x;
         ref_vel[1] = req_start_vel_y;
         ref_vel[2] = req_start_vel_z;
         wn_held = wn_reg;
         xi_held = xi_reg;
         return;
      end
      if (!mode[vgr_pkg::MODE_CTRL]) return;
      tgt[0] = req_target_x;
      tgt[1] = req_target_y;
      tgt[2] = clamp32(-q_type'(req_target_z));
      if (mode[vgr_pkg::MODE_REF]) begin
         dt    = q_type'(req_dt);
         wn2   = qmul(q_type'(wn_held), q_type'(wn_held));
         damp2 = clamp32(qmul(q_type'(wn_held), q_type'(xi_held)) * 2);
         for (int i = 0; i < 3; i++) begin
            err = clamp32(tgt[i] - ref_pos[i]);
            acc = clamp32(qmul(wn2, err) - qmul(damp2, ref_vel[i]));
            ref_pos[i] = clamp32(ref_pos[i] + qmul(dt, ref_vel[i]));
            ref_vel[i] = clamp32(ref_vel[i] + qmul(dt, acc));
         end
         vec = ref_vel;
         if (!alt) vec[2] = 0;
         if (clip_norm(vec, 64'(ref_max_spd))) ref_vel = vec;
         for (int i = 0; i < 3; i++)
            cmd[i] = clamp32(ref_vel[i] +
                             qmul(q_type'(gain_reg), clamp32(ref_pos[i] - pos[i])));
      end else begin
         for (int i = 0; i < 3; i++)
            cmd[i] = qmul(q_type'(gain_reg), clamp32(tgt[i] - pos[i]));
      end
      if (!alt) cmd[2] = 0;
      void'(clip_norm(cmd, 64'(max_spd)));
      c.u = cmd[0][31:0];
      c.v = cmd[1][31:0];
      c.w = cmd[2][31:0];
      c.heave = !mode[vgr_pkg::MODE_NOHV];
      has_cmd = 1;
   endfunction

   always @(posedge clock) begin
      bit      has_cmd;
      cmd_type c, e;
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            ref_pos[i] = 0;
            ref_vel[i] = 0;
         end
         mode = vgr_pkg::MODE_RST;
         max_spd = vgr_pkg::MAX_RST;
         ref_max_spd = vgr_pkg::REFMAX_RST;
         wn_reg = vgr_pkg::FREQ_RST;
         xi_reg = vgr_pkg::DAMP_RST;
         gain_reg = vgr_pkg::GAIN_RST;
         wn_held = vgr_pkg::FREQ_RST;
         xi_held = vgr_pkg::DAMP_RST;
         expected_cmds.delete();
         fail_count = 0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               vgr_pkg::CSR_MODE:   mode = csr_wdata[3:0];
               vgr_pkg::CSR_MAX:    max_spd = csr_wdata[30:0];
               vgr_pkg::CSR_REFMAX: ref_max_spd = csr_wdata[30:0];
               vgr_pkg::CSR_FREQ:   wn_reg = csr_wdata[19:0];
               vgr_pkg::CSR_DAMP:   xi_reg = csr_wdata[17:0];
               vgr_pkg::CSR_GAIN:   gain_reg = csr_wdata[19:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            guidance_step(has_cmd, c);
            if (has_cmd) expected_cmds.push_back(c);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_cmds.size() == 0) begin
               $error("unexpected command transfer u=%0d v=%0d w=%0d",
                      rsp_cmd_u, rsp_cmd_v, rsp_cmd_w);
               fail_count++;
            end else begin
               e = expected_cmds.pop_front();
               if (rsp_cmd_u !== e.u) begin
                  $error("cmd_u expected %0d got %0d", e.u, rsp_cmd_u);
                  fail_count++;
               end
               if (rsp_cmd_v !== e.v) begin
                  $error("cmd_v expected %0d got %0d", e.v, rsp_cmd_v);
                  fail_count++;
               end
               if (rsp_cmd_w !== e.w) begin
                  $error("cmd_w expected %0d got %0d", e.w, rsp_cmd_w);
                  fail_count++;
               end
               if (rsp_heave_valid !== e.heave) begin
                  $error("heave_valid expected %0b got %0b", e.heave, rsp_heave_valid);
                  fail_count++;
               end
            end
         end
      end
   end
endmodule

// File: tb/velocity_guidance_refmodel_core_tb.sv
module velocity_guidance_refmodel_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 2000000;
   localparam int SETTLE_CYCLES = 450;
   localparam logic [31:0] QMAX = 32'h7FFFFFFF;
   localparam logic [31:0] QMIN = 32'h80000000;

   logic clock, reset;
   logic req_valid, req_stall, req_op;
   logic signed [31:0] req_pos_x, req_pos_y, req_pos_z;
   logic signed [31:0] req_start_vel_x, req_start_vel_y, req_start_vel_z;
   logic signed [31:0] req_target_x, req_target_y, req_target_z;
   logic [16:0] req_dt;
   logic rsp_valid, rsp_stall, rsp_heave_valid;
   logic signed [31:0] rsp_cmd_u, rsp_cmd_v, rsp_cmd_w;
   logic csr_wr_en;
   logic [vgr_pkg::CSR_AW-1:0] csr_index;
   logic [vgr_pkg::CSR_DW-1:0] csr_wdata;
   int fail_count, cmds_pending;
   int send_idle_pct, recv_idle_pct;
   int cycles = 0;

   velocity_guidance_refmodel_core dut (.*);
   velocity_guidance_refmodel_core_chk chk (.*);

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("[velocity_guidance_refmodel_core] ERROR");
         $finish;
      end
   end

   always @(posedge clock)
      rsp_stall <= reset ? 1'b0 : ($urandom_range(99) < recv_idle_pct);

   task automatic drive_item(input bit op, input logic [31:0] px, py, pz,
                             input logic [31:0] vx, vy, vz, tx, ty, tz,
                             input logic [16:0] dt);
      bit taken;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid <= 1;
      req_op <= op;
      req_pos_x <= px;
      req_pos_y <= py;
      req_pos_z <= pz;
      req_start_vel_x <= vx;
      req_start_vel_y <= vy;
      req_start_vel_z <= vz;
      req_target_x <= tx;
      req_target_y <= ty;
      req_target_z <= tz;
      req_dt <= dt;
      forever begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
         if (taken) break;
      end
   endtask

   // wait until all commands are out and the core has had time to go quiet
   task automatic drain();
      req_valid <= 0;
      do @(negedge clock); while (cmds_pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_regs(input logic [30:0] md, mx, rmx, wn, xi, kp);
      logic [30:0] vals[6];
      vals = '{md, mx, rmx, wn, xi, kp};
      for (int i = 0; i < 6; i++) begin
         csr_wr_en <= 1;
         csr_index <= vgr_pkg::CSR_AW'(i);
         csr_wdata <= vals[i];
         @(posedge clock);
      end
      csr_wr_en <= 0;
      @(posedge clock);
   endtask

   // mostly metres-scale values, sometimes anything the field holds
   function automatic logic [31:0] rand_q();
      case ($urandom_range(7))
         0:       return $urandom;
         1:       return $urandom_range(1) ? QMAX : QMIN;
         default: return $urandom_range(13107200) - 6553600;
      endcase
   endfunction

   function automatic logic [16:0] rand_dt();
      case ($urandom_range(5))
         0:       return 17'($urandom_range(65536));
         1:       return $urandom_range(1) ? 17'd65536 : 17'd0;
         default: return 17'($urandom_range(1000, 13107));
      endcase
   endfunction

   task automatic random_item(input bit op);
      drive_item(op, rand_q(), rand_q(), rand_q(), rand_q(), rand_q(), rand_q(),
                 rand_q(), rand_q(), rand_q(), rand_dt());
   endtask

   task automatic run_random(input int n_items, input bit hold_once);
      int sent;
      sent = 0;
      while (sent < n_items) begin
         if ($urandom_range(9) == 0) begin
            random_item(1'($urandom_range(1)));
            sent++;
         end else begin
            random_item(vgr_pkg::OP_START);
            repeat ($urandom_range(4, 14)) begin
               random_item(vgr_pkg::OP_STEP);
               sent++;
            end
         end
         if (hold_once && sent > n_items / 2) begin
            hold_once = 0;
            req_valid <= 0;
            do @(negedge clock); while (cmds_pending != 0);
            @(posedge clock);
         end
      end
   endtask

   initial begin
      reset = 1;
      req_valid = 0;
      req_op = vgr_pkg::OP_STEP;
      {req_pos_x, req_pos_y, req_pos_z} = '0;
      {req_start_vel_x, req_start_vel_y, req_start_vel_z} = '0;
      {req_target_x, req_target_y, req_target_z} = '0;
      req_dt = 0;
      csr_wr_en = 0;
      csr_index = '0;
      csr_wdata = '0;
      send_idle_pct = 34;
      recv_idle_pct = 49;
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      write_regs(7, 327680, 196608, 655360, 131072, 655360);
      drive_item(vgr_pkg::OP_START, QMAX, QMIN, QMAX, QMIN, QMAX, QMIN, 0, 0, 0, 0);
      drive_item(vgr_pkg::OP_STEP, 0, 0, 0, 0, 0, 0, QMAX, QMIN, QMIN, 17'd65536);
      drive_item(vgr_pkg::OP_STEP, QMIN, QMAX, QMIN, 0, 0, 0, QMIN, QMAX, QMAX, 17'd0);
      drive_item(vgr_pkg::OP_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 17'd65536);
      drive_item(vgr_pkg::OP_START, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      drive_item(vgr_pkg::OP_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 17'd6554);
      drive_item(vgr_pkg::OP_STEP, 0, 0, 0, 0, 0, 0, 655360, -655360, 327680, 17'd6554);
      drive_item(vgr_pkg::OP_STEP, QMAX, QMAX, QMAX, QMAX, QMAX, QMAX, QMAX, QMAX, QMAX,
                 17'h1FFFF);
      drive_item(vgr_pkg::OP_START, -65536, 65536, -65536, QMAX, QMAX, QMAX, 0, 0, 0, 0);
      drive_item(vgr_pkg::OP_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 17'd65536);
      drive_item(vgr_pkg::OP_STEP, 32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA, 32'h55555555,
                 32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA, 32'h55555555,
                 32'hAAAAAAAA, 17'h0AAAA);
      drive_item(vgr_pkg::OP_STEP, 32'h55555555, 32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA,
                 32'h55555555, 32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA,
                 32'h55555555, 17'h15555);
      run_random(90, 0);
      drain();

      write_regs(3, 0, 31'h7FFFFFFF, 6554, 58982, 6554);
      run_random(100, 1);
      drain();

      write_regs(15, 31'h7FFFFFFF, 0, 0, 0, 0);
      run_random(90, 0);
      drain();

      send_idle_pct = 49;
      recv_idle_pct = 34;
      write_regs(1, 655360, 131072, 131072, 45875, 65536);
      run_random(100, 0);
      drain();

      // controller off: steps give nothing, starts still load state
      write_regs(0, 327680, 196608, 6554, 58982, 6554);
      run_random(30, 0);
      drain();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_regs(11, 31'($urandom_range(1, 2000000)), 31'($urandom_range(1, 1000000)),
                 31'($urandom_range(655360)), 31'($urandom_range(131072)),
                 31'($urandom_range(655360)));
      run_random(100, 0);
      drain();

      write_regs(5, 196608, 131072, 32768, 65536, 32768);
      run_random(100, 0);
      drain();

      if (fail_count == 0)
         $display("[velocity_guidance_refmodel_core] OK");
      else
         $display("[velocity_guidance_refmodel_core] ERROR");
      $finish;
   end
endmodule
